@@ hdl/rr_pkg.sv @@
package rr_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef enum logic [1:0] {
        DIV_EUCLID,
        DIV_NUM,
        DIV_DEN
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_start;
        div_sel_t div_sel;
        logic     eu_step;
        logic     store_qn;
        logic     store_qd;
        logic     out_load;
    } rr_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic y_zero;
        logic div_done;
    } rr_stat_t;

endpackage

@@ hdl/rr_divider.sv @@
module rr_divider
    import rr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DATA_WIDTH-1:0] dividend,
    input  logic [DATA_WIDTH-1:0] divisor,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic [DATA_WIDTH-1:0] remainder
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] dvs_reg;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   rem_sub;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[DATA_WIDTH-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        if (!rem_sub[DATA_WIDTH]) begin
            rem_next = rem_sub[DATA_WIDTH-1:0];
            quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
        end else begin
            rem_next = rem_sh[DATA_WIDTH-1:0];
            quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_WIDTH - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/rr_datapath.sv @@
module rr_datapath
    import rr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rr_cmd_t               cmd,
    output rr_stat_t              stat,
    input  logic [DATA_WIDTH-1:0] num_in,
    input  logic [DATA_WIDTH-1:0] den_in,
    output logic [DATA_WIDTH-1:0] num_out,
    output logic [DATA_WIDTH-2:0] den_out
);

    localparam logic [DATA_WIDTH-1:0] MagTop = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic [DATA_WIDTH-1:0] a_reg, b_reg, x_reg, y_reg, qn_reg, qd_reg;
    logic                  neg_reg, zero_reg;
    logic [DATA_WIDTH-1:0] num_out_reg;
    logic [DATA_WIDTH-2:0] den_out_reg;
    logic [DATA_WIDTH-1:0] n_mag, d_mag, qn_clamp, qd_clamp;
    logic [DATA_WIDTH-1:0] dividend, divisor, quotient, remainder;
    logic                  div_done;

    assign n_mag = num_in[DATA_WIDTH-1] ? (~num_in + 1'b1) : num_in;
    assign d_mag = den_in[DATA_WIDTH-1] ? (~den_in + 1'b1) : den_in;

    always_comb begin
        case (cmd.div_sel)
            DIV_EUCLID: dividend = x_reg;
            DIV_NUM:    dividend = a_reg;
            DIV_DEN:    dividend = b_reg;
            default:    dividend = x_reg;
        endcase
        divisor = (cmd.div_sel == DIV_EUCLID) ? y_reg : x_reg;
    end

    rr_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (dividend),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // saturate magnitudes that do not fit the positive range
    assign qn_clamp = qn_reg[DATA_WIDTH-1] ? MagTop : qn_reg;
    assign qd_clamp = qd_reg[DATA_WIDTH-1] ? MagTop : qd_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg    <= n_mag;
            b_reg    <= d_mag;
            x_reg    <= n_mag;
            y_reg    <= d_mag;
            neg_reg  <= num_in[DATA_WIDTH-1] ^ den_in[DATA_WIDTH-1];
            zero_reg <= (num_in == '0);
        end else if (cmd.eu_step) begin
            x_reg <= y_reg;
            y_reg <= remainder;
        end
        if (cmd.store_qn) begin
            qn_reg <= quotient;
        end
        if (cmd.store_qd) begin
            qd_reg <= quotient;
        end
        if (cmd.out_load) begin
            if (zero_reg) begin
                num_out_reg <= '0;
                den_out_reg <= (DATA_WIDTH-1)'(1);
            end else begin
                num_out_reg <= neg_reg ? (~qn_clamp + 1'b1) : qn_clamp;
                den_out_reg <= qd_clamp[DATA_WIDTH-2:0];
            end
        end
    end

    assign stat.n_zero   = zero_reg;
    assign stat.y_zero   = (y_reg == '0);
    assign stat.div_done = div_done;

    assign num_out = num_out_reg;
    assign den_out = den_out_reg;

endmodule

@@ hdl/rr_ctrl.sv @@
module rr_ctrl
    import rr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  rr_stat_t stat,
    output rr_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_EU_TEST,
        S_EU_WAIT,
        S_DN_WAIT,
        S_DD_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.div_sel  = DIV_EUCLID;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = stat.n_zero ? S_FINISH : S_EU_TEST;
            end
            S_EU_TEST: begin
                cmd.div_start = 1'b1;
                if (stat.y_zero) begin
                    cmd.div_sel = DIV_NUM;
                    state_next  = S_DN_WAIT;
                end else begin
                    state_next  = S_EU_WAIT;
                end
            end
            S_EU_WAIT: begin
                if (stat.div_done) begin
                    cmd.eu_step = 1'b1;
                    state_next  = S_EU_TEST;
                end
            end
            S_DN_WAIT: begin
                cmd.div_sel = DIV_DEN;
                if (stat.div_done) begin
                    cmd.store_qn  = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_DD_WAIT;
                end
            end
            S_DD_WAIT: begin
                if (stat.div_done) begin
                    cmd.store_qd = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

@@ hdl/rational_reduce_unit.sv @@
// Rational reduction unit: puts a signed fraction num/den into lowest terms.
// Input channel (s_valid/s_ready, s_num_in, s_den_in): one transaction is one
// fraction. Output channel (m_valid/m_ready, m_num_out, m_den_out): one
// transaction per input, carrying the sign on the numerator and a
// nonnegative denominator. A zero numerator gives 0/1; a zero denominator
// with a nonzero numerator gives +1/0 or -1/0.
// A zero numerator goes from the check straight to the output write.
// Otherwise Euclid's loop runs remainder steps on the two magnitudes (none
// when the denominator is zero), then the numerator and denominator are
// divided by the gcd. All remainders and both final quotients go through
// one shared restoring divider that retires one quotient bit per cycle.
// One fraction is in work at a time; the next is accepted the cycle after the
// current result is written to the output register.
// Reset (aresetn low, synchronous) returns the controller to idle and drops
// any pending result. When the receiver stalls, the result holds in the
// output register and a newly accepted fraction is worked on meanwhile; it
// waits for the register to free before it is written.
module rational_reduce_unit
    import rr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_num_in,
    input  logic [DATA_WIDTH-1:0] s_den_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_WIDTH-1:0] m_num_out,
    output logic [DATA_WIDTH-2:0] m_den_out
);

    rr_cmd_t  cmd;
    rr_stat_t stat;

    // sequence the load, Euclid loop, two divisions and output write
    rr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // hold operands, the shared divider and the output register
    rr_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .num_in  (s_num_in),
        .den_in  (s_den_in),
        .num_out (m_num_out),
        .den_out (m_den_out)
    );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench
    import rr_pkg::*;
();

    localparam int DW = DATA_WIDTH;
    // Largest positive magnitude and the most negative value, which the input range excludes.
    localparam logic [DW-1:0] MAG_MAX  = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam int RAND_ITEMS = 1150;
    // Worst case is near 50 remainder steps; allow plenty on top.
    localparam int SETTLE_CYCLES = 2000;
    localparam int HOLD_OFF      = 4000;
    localparam int CYCLE_LIMIT   = 10_000_000;

    typedef struct packed {
        logic [DW-1:0] num;
        logic [DW-1:0] den;
    } frac_in_t;

    typedef struct packed {
        logic [DW-1:0] num;
        logic [DW-2:0] den;
    } frac_out_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_valid   = 1'b0;
    logic          s_ready;
    logic [DW-1:0] s_num_in  = '0;
    logic [DW-1:0] s_den_in  = '0;
    logic          m_valid;
    logic          m_ready   = 1'b0;
    logic [DW-1:0] m_num_out;
    logic [DW-2:0] m_den_out;

    frac_in_t  frac_queue[$];      // fractions waiting to be offered
    frac_out_t expected_fracs[$];  // reduced fractions still owed by the block
    int        mismatches   = 0;
    int        results_seen = 0;
    int        cycle_cnt    = 0;
    int        tx_gap       = 0;
    int        tx_burst     = 0;
    int        rx_wait      = 0;
    int        rx_burst     = 0;

    rational_reduce_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_num_in  (s_num_in),
        .s_den_in  (s_den_in),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_num_out (m_num_out),
        .m_den_out (m_den_out)
    );

    always #10 aclk = ~aclk;

    // Put num/den into lowest terms: Euclid on the magnitudes, divide both by the gcd,
    // saturate, and carry the sign of the fraction on the numerator.
    function automatic frac_out_t reduce_fraction(input logic [DW-1:0] n,
                                                  input logic [DW-1:0] d);
        frac_out_t     r;
        logic [DW-1:0] a, b, t, qn, qd;
        logic          neg;
        if (n == '0) begin
            r.num = '0;
            r.den = (DW-1)'(1);
            return r;
        end
        // A zero denominator counts as positive, so only its sign bit matters.
        neg = n[DW-1] ^ d[DW-1];
        a   = n[DW-1] ? (~n + 1'b1) : n;
        b   = d[DW-1] ? (~d + 1'b1) : d;
        qn  = a;
        qd  = b;
        while (b != '0) begin
            t = a % b;
            a = b;
            b = t;
        end
        qn = qn / a;
        qd = qd / a;
        if (qn > MAG_MAX)
            qn = MAG_MAX;
        if (qd > MAG_MAX)
            qd = MAG_MAX;
        r.num = neg ? (~qn + 1'b1) : qn;
        r.den = qd[DW-2:0];
        return r;
    endfunction

    // Advance a no-idle stretch, or start a new one now and then.
    function automatic int next_burst(input int b);
        if (b > 0)
            return b - 1;
        if ($urandom_range(0, 39) == 0)
            return $urandom_range(15, 40);
        return 0;
    endfunction

    // Any value of the field range; the most negative pattern is stepped over.
    function automatic logic [DW-1:0] any_value();
        logic [63:0]   wide;
        logic [DW-1:0] v;
        wide = {$urandom, $urandom};
        v    = wide[DW-1:0];
        if (v == MOST_NEG)
            v = v + 1'b1;
        return v;
    endfunction

    function automatic logic [DW-1:0] with_sign(input logic [DW-1:0] mag);
        return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
    endfunction

    // Mostly small and medium magnitudes keep Euclid short; a slice spans the full range.
    function automatic frac_in_t random_fraction();
        frac_in_t f;
        int       kind;
        int       g;
        kind = $urandom_range(0, 99);
        if (kind < 4) begin
            f.num = '0;
            f.den = any_value();
        end else if (kind < 8) begin
            f.num = any_value();
            f.den = '0;
        end else if (kind < 18) begin
            f.num = any_value();
            f.den = any_value();
        end else if (kind < 45) begin
            // shared factor g, so the gcd is a multiple of g
            g     = $urandom_range(1, 4096);
            f.num = with_sign(DW'(g * $urandom_range(1, 4096)));
            f.den = with_sign(DW'(g * $urandom_range(1, 4096)));
        end else if (kind < 75) begin
            f.num = with_sign(DW'($urandom_range(1, 255)));
            f.den = with_sign(DW'($urandom_range(0, 255)));
        end else begin
            f.num = with_sign(DW'($urandom_range(1, 65535)));
            f.den = with_sign(DW'($urandom_range(0, 65535)));
        end
        return f;
    endfunction

    task automatic add_frac(input logic [DW-1:0] n, input logic [DW-1:0] d);
        frac_in_t f;
        f.num = n;
        f.den = d;
        frac_queue.push_back(f);
    endtask

    // Hold until every queued fraction is accepted and every result has come back.
    // Check on the falling edge, once the clocked blocks have settled.
    task automatic drain();
        while (frac_queue.size() != 0 || s_valid || expected_fracs.size() != 0)
            @(negedge aclk);
    endtask

    // Driver: offer one fraction per transaction; hold the payload until accepted,
    // then idle for a drawn number of cycles before offering the next.
    always @(posedge aclk) begin
        frac_in_t cur;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_fracs.push_back(reduce_fraction(s_num_in, s_den_in));
                tx_burst = next_burst(tx_burst);
                tx_gap   = (tx_burst > 0) ? 0 : $urandom_range(0, 17);
            end
            // Drive only when nothing is left pending, so valid sees one assignment per edge.
            if (!(s_valid && !s_ready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (frac_queue.size() != 0) begin
                    cur = frac_queue.pop_front();
                    s_valid  <= 1'b1;
                    s_num_in <= cur.num;
                    s_den_in <= cur.den;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction with the oldest expectation, then
    // stall for a drawn number of cycles. Twice in the run, hold off long enough
    // that the output register and the working slot both fill and s_ready drops.
    always @(posedge aclk) begin
        frac_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_fracs.size() == 0) begin
                    $error("unexpected result: num_out %0d, den_out %0d",
                           $signed(m_num_out), m_den_out);
                    mismatches++;
                end else begin
                    want = expected_fracs.pop_front();
                    if (m_num_out !== want.num) begin
                        $error("num_out: expected %0d, actual %0d",
                               $signed(want.num), $signed(m_num_out));
                        mismatches++;
                    end
                    if (m_den_out !== want.den) begin
                        $error("den_out: expected %0d, actual %0d", want.den, m_den_out);
                        mismatches++;
                    end
                end
                if (results_seen == 150 || results_seen == 700) begin
                    rx_wait = HOLD_OFF;
                end else begin
                    rx_burst = next_burst(rx_burst);
                    rx_wait  = (rx_burst > 0) ? 0 : $urandom_range(0, 17);
                end
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero numerator, zero denominator, field extremes, all sign
        // combinations, coprime and shared-factor pairs, and a long Euclid chain.
        add_frac(0, 5);
        add_frac(0, 0);
        add_frac(0, -7);
        add_frac(0, MAG_MAX);
        add_frac(5, 0);
        add_frac(-5, 0);
        add_frac(MAG_MAX, 0);
        add_frac(-MAG_MAX, 0);
        add_frac(MAG_MAX, MAG_MAX);
        add_frac(-MAG_MAX, MAG_MAX);
        add_frac(MAG_MAX, -MAG_MAX);
        add_frac(-MAG_MAX, -MAG_MAX);
        add_frac(1, 1);
        add_frac(-1, 1);
        add_frac(6, -4);
        add_frac(-6, -4);
        add_frac(12, 18);
        add_frac(MAG_MAX, 1);
        add_frac(1, -MAG_MAX);
        add_frac(-MAG_MAX, -1);
        add_frac(1836311903, 1134903170);    // consecutive Fibonacci: longest chain
        add_frac(-1134903170, 1836311903);
        add_frac(32'h5555_5555, 32'hAAAA_AAAB);
        add_frac(1 << 30, -(1 << 30));
        add_frac(MAG_MAX - 1, 2);

        // Pause the sender until every directed result is back.
        drain();

        for (i = 0; i < RAND_ITEMS; i++)
            frac_queue.push_back(random_fraction());

        drain();
        // Watch for stray results after the last expected one.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
